>>> rtl/assert_macros.svh
// Assertion helpers; the assertions drop out when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, sampled on clk, off during rst.
`define BPFD_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("block palette decoder check failed");
// Next-cycle implication, sampled on clk, off during rst.
`define BPFD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("block palette decoder check failed");
`else
`define BPFD_ASSERT(lbl, ante, cons)
`define BPFD_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> rtl/bpfd_pkg.sv
package bpfd_pkg;

  localparam int BLOCK_SIZE  = 8;
  localparam int BLOCK_SHIFT = 3;
  localparam int BYTE_W      = 8;
  localparam int PIX_W       = 10;
  localparam int COLOR_W     = 24;
  localparam int PSIZE_BITS  = 3;
  localparam int NEED_W      = 5;
  localparam int FILL_W      = 8;
  localparam int INDEX_W     = 7;
  localparam int PIB_W       = 6;
  localparam int AREA_W      = 7;

  localparam int DEF_MAX_DIM       = 1024;
  localparam int DEF_PALETTE_DEPTH = 256;

  // configuration port
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;
  localparam logic [CFG_W-1:0]     RESET_WIDTH      = 11'd320;
  localparam logic [CFG_W-1:0]     RESET_HEIGHT     = 11'd240;

  typedef struct packed {
    logic [BYTE_W-1:0] in_byte;
    logic              frame_start;
  } in_t;

  typedef struct packed {
    logic               write_enable;
    logic [PIX_W-1:0]   pixel_x;
    logic [PIX_W-1:0]   pixel_y;
    logic [COLOR_W-1:0] pixel_color;
    logic               last_of_run;
    logic               frame_done;
  } out_t;

  // Quotient of a pixel number (0..63) by a tile width (1..8):
  // multiply by a rounded-up reciprocal scaled by 2^9, exact for this range.
  function automatic logic [PIB_W-1:0] tile_quot(input logic [PIB_W-1:0] pix,
                                                 input logic [3:0] span);
    logic [9:0]  recip;
    logic [15:0] prod;
    case (span)
      4'd2:    recip = 10'd256;
      4'd3:    recip = 10'd171;
      4'd4:    recip = 10'd128;
      4'd5:    recip = 10'd103;
      4'd6:    recip = 10'd86;
      4'd7:    recip = 10'd74;
      4'd8:    recip = 10'd64;
      default: recip = 10'd512;
    endcase
    prod = 16'(pix) * 16'(recip);
    return prod[14:9];
  endfunction

endpackage

>>> rtl/block_palette_frame_decoder.sv
// Steps: a word is taken while idle, then its eight bits are parsed, MSB first; each
//   pixel write adds a quotient step and an emit step (the emit waits for room at the
//   output), and a closing step puts the last result in the output register.
// A new word is taken only after the last one is closed (in_ready only while idle).
// Reset (synchronous, rst high): parser and tile position cleared, size 320 x 240,
//   frame finished until a word with frame_start; the palette memory is not cleared.
`include "assert_macros.svh"

module block_palette_frame_decoder #(
  parameter int MAX_DIM       = bpfd_pkg::DEF_MAX_DIM,
  parameter int PALETTE_DEPTH = bpfd_pkg::DEF_PALETTE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  bpfd_pkg::in_t                  in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output bpfd_pkg::out_t                 out_data,
  input  logic                           cfg_we,
  input  logic [bpfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bpfd_pkg::CFG_W-1:0]     cfg_wdata
);

  localparam int AddrW   = $clog2(PALETTE_DEPTH);
  localparam int EffW    = $clog2(MAX_DIM + 1);
  localparam int BlkRaw  = $clog2((MAX_DIM + bpfd_pkg::BLOCK_SIZE - 1) / bpfd_pkg::BLOCK_SIZE);
  localparam int BlkW    = (BlkRaw > 0) ? BlkRaw : 1;
  localparam int OrgW    = BlkW + bpfd_pkg::BLOCK_SHIFT;
  localparam int ExtW    = (OrgW + 1 > EffW) ? OrgW + 1 : EffW;
  localparam int SumW    = (OrgW > bpfd_pkg::PIB_W) ? OrgW + 1 : bpfd_pkg::PIB_W + 1;
  localparam int PixW    = bpfd_pkg::PIX_W;
  localparam int ColorW  = bpfd_pkg::COLOR_W;
  localparam int NeedW   = bpfd_pkg::NEED_W;
  localparam int FillW   = bpfd_pkg::FILL_W;
  localparam int PibW    = bpfd_pkg::PIB_W;
  localparam int AreaW   = bpfd_pkg::AREA_W;
  localparam int ByteW   = bpfd_pkg::BYTE_W;

  typedef enum logic [2:0] {
    ST_IDLE,   // wait for a word
    ST_BIT,    // parse one bit of the word per cycle
    ST_QUO,    // split the pixel number into row and column
    ST_EMIT,   // form one pixel write
    ST_END     // close the word's results
  } state_t;

  typedef enum logic [1:0] {
    PH_UPDATE,
    PH_PSIZE,
    PH_COLOR,
    PH_INDEX
  } phase_t;

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  state_t               state, state_next;
  phase_t               phase, phase_next;
  logic [2:0]           nbits, nbits_next;        // bits of the word already parsed
  logic [ByteW-1:0]     shreg, shreg_next;        // word bits, MSB leaves first
  logic [ColorW-1:0]    acc, acc_next;            // field shift register
  logic [NeedW-1:0]     need, need_next;          // bits still missing in the field
  logic [2:0]           pbits, pbits_next;        // palette index width P
  logic [FillW-1:0]     fill_cnt, fill_cnt_next;  // palette entries loaded
  logic [BlkW-1:0]      col, col_next;
  logic [BlkW-1:0]      row, row_next;
  logic [PibW-1:0]      pib, pib_next;            // pixel number inside the tile
  logic                 finished, finished_next;
  logic                 fill_mode, fill_mode_next;
  logic [ColorW-1:0]    fill_color, fill_color_next;
  logic [PibW-1:0]      quo, quo_next;
  logic                 pend_v, pend_v_next;      // newest write, held until the next
  bpfd_pkg::out_t       pend, pend_next;          // one shows whether it is last
  logic                 out_valid_next;
  bpfd_pkg::out_t       out_data_next;
  logic [bpfd_pkg::CFG_W-1:0] cfg_w, cfg_w_next;
  logic [bpfd_pkg::CFG_W-1:0] cfg_h, cfg_h_next;

  // palette memory
  logic [ColorW-1:0]    pal_mem [PALETTE_DEPTH];
  logic [ColorW-1:0]    rd_data;
  logic                 mem_we, mem_re;
  logic [AddrW-1:0]     mem_waddr, mem_raddr;

  // ---------------------------------------------------------------------------
  // Tile geometry
  // ---------------------------------------------------------------------------
  logic [EffW-1:0]      eff_w, eff_h;
  logic [OrgW-1:0]      x0, y0;
  logic [3:0]           tw, th;
  logic [AreaW-1:0]     area;
  logic [BlkW:0]        col_inc, row_inc;
  logic                 col_wrap, row_wrap;

  function automatic logic [3:0] extent(input logic [OrgW-1:0] org,
                                        input logic [EffW-1:0] lim);
    logic [ExtW-1:0] o;
    logic [ExtW-1:0] l;
    logic [ExtW-1:0] d;
    o = ExtW'(org);
    l = ExtW'(lim);
    d = l - o;
    if (o >= l) begin
      return 4'd1;
    end else if (d < ExtW'(bpfd_pkg::BLOCK_SIZE)) begin
      return d[3:0];
    end else begin
      return 4'(bpfd_pkg::BLOCK_SIZE);
    end
  endfunction

  // Saturate the configured size to MAX_DIM.
  assign eff_w = (32'(cfg_w) > MAX_DIM) ? EffW'(MAX_DIM) : EffW'(cfg_w);
  assign eff_h = (32'(cfg_h) > MAX_DIM) ? EffW'(MAX_DIM) : EffW'(cfg_h);

  assign x0   = {col, 3'b000};
  assign y0   = {row, 3'b000};
  assign tw   = extent(x0, eff_w);
  assign th   = extent(y0, eff_h);
  assign area = AreaW'({4'b0000, tw} * {4'b0000, th});

  // Tile advance: the next column, or the next row once past the right edge.
  assign col_inc  = {1'b0, col} + 1'b1;
  assign row_inc  = {1'b0, row} + 1'b1;
  assign col_wrap = ExtW'({col_inc, 3'b000}) >= ExtW'(eff_w);
  assign row_wrap = ExtW'({row_inc, 3'b000}) >= ExtW'(eff_h);

  // ---------------------------------------------------------------------------
  // Bit and pixel datapath
  // ---------------------------------------------------------------------------
  logic                 cur_bit;
  logic [ColorW-1:0]    acc_shift;
  logic [NeedW-1:0]     need_dec;
  logic [FillW-1:0]     fill_inc;
  logic [9:0]           quo_prod;
  logic [PibW-1:0]      rem_full;
  logic [SumW-1:0]      x_sum, y_sum;
  logic [PibW:0]        pib_inc;
  logic                 out_free;
  logic                 tile_adv;
  bpfd_pkg::out_t       pix_word;
  bpfd_pkg::out_t       close_word;

  assign cur_bit   = shreg[ByteW-1];
  assign acc_shift = {acc[ColorW-2:0], cur_bit};
  assign need_dec  = (need == '0) ? '0 : need - 1'b1;
  assign fill_inc  = fill_cnt + 1'b1;
  assign pib_inc   = {1'b0, pib} + 1'b1;
  assign out_free  = !out_valid || out_ready;

  // Column is the remainder left after the registered quotient.
  assign quo_prod = {4'b0000, quo} * {6'b000000, tw};
  assign rem_full = pib - quo_prod[PibW-1:0];
  assign x_sum    = SumW'(x0) + SumW'(rem_full[2:0]);
  assign y_sum    = SumW'(y0) + SumW'(quo);

  always_comb begin
    pix_word              = '0;
    pix_word.write_enable = 1'b1;
    pix_word.pixel_x      = PixW'(x_sum);
    pix_word.pixel_y      = PixW'(y_sum);
    pix_word.pixel_color  = fill_mode ? fill_color : rd_data;
    pix_word.frame_done   = finished;
  end

  // Final result of a word: the held write, or a status word when none.
  always_comb begin
    if (pend_v) begin
      close_word = pend;
    end else begin
      close_word = '0;
    end
    close_word.last_of_run = 1'b1;
    close_word.frame_done  = finished;
  end

  always_comb begin
    state_next      = state;
    phase_next      = phase;
    nbits_next      = nbits;
    shreg_next      = shreg;
    acc_next        = acc;
    need_next       = need;
    pbits_next      = pbits;
    fill_cnt_next   = fill_cnt;
    col_next        = col;
    row_next        = row;
    pib_next        = pib;
    finished_next   = finished;
    fill_mode_next  = fill_mode;
    fill_color_next = fill_color;
    quo_next        = quo;
    pend_v_next     = pend_v;
    pend_next       = pend;
    out_valid_next  = out_valid && !out_ready;
    out_data_next   = out_data;
    cfg_w_next      = cfg_w;
    cfg_h_next      = cfg_h;
    mem_we          = 1'b0;
    mem_re          = 1'b0;
    mem_waddr       = AddrW'(fill_cnt);
    mem_raddr       = AddrW'(acc_shift[bpfd_pkg::INDEX_W-1:0]);
    tile_adv        = 1'b0;

    if (cfg_we) begin
      unique case (cfg_index)
        bpfd_pkg::REG_IMAGE_WIDTH:  cfg_w_next = cfg_wdata;
        bpfd_pkg::REG_IMAGE_HEIGHT: cfg_h_next = cfg_wdata;
      endcase
    end

    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          shreg_next = in_data.in_byte;
          nbits_next = '0;
          state_next = ST_BIT;
          // Frame start: restart the tile walk and the parser.
          if (in_data.frame_start) begin
            phase_next    = PH_UPDATE;
            acc_next      = '0;
            need_next     = NeedW'(1);
            pbits_next    = '0;
            fill_cnt_next = '0;
            col_next      = '0;
            row_next      = '0;
            pib_next      = '0;
            finished_next = (eff_w == '0) || (eff_h == '0);
          end
        end
      end

      ST_BIT: begin
        shreg_next = {shreg[ByteW-2:0], 1'b0};
        nbits_next = nbits + 1'b1;
        state_next = (nbits == 3'd7) ? ST_END : ST_BIT;
        // Once the frame is finished, drop bits until the next frame start.
        if (!finished) begin
          acc_next  = acc_shift;
          need_next = need_dec;
          if (need_dec == '0) begin
            acc_next = '0;
            unique case (phase)
              PH_UPDATE: begin
                if (acc_shift[0]) begin
                  phase_next = PH_PSIZE;
                  need_next  = NeedW'(bpfd_pkg::PSIZE_BITS);
                end else begin
                  tile_adv = 1'b1;
                end
              end
              PH_PSIZE: begin
                pbits_next    = acc_shift[2:0];
                fill_cnt_next = '0;
                phase_next    = PH_COLOR;
                need_next     = NeedW'(ColorW);
              end
              PH_COLOR: begin
                mem_we        = 1'b1;
                fill_cnt_next = fill_inc;
                if (fill_inc < (FillW'(1) << pbits)) begin
                  need_next = NeedW'(ColorW);
                end else if (pbits != '0) begin
                  phase_next = PH_INDEX;
                  pib_next   = '0;
                  need_next  = NeedW'(pbits);
                end else begin
                  // Single colour: fill the whole tile with it.
                  fill_color_next = acc_shift;
                  fill_mode_next  = 1'b1;
                  pib_next        = '0;
                  state_next      = ST_QUO;
                end
              end
              PH_INDEX: begin
                mem_re         = 1'b1;
                fill_mode_next = 1'b0;
                state_next     = ST_QUO;
              end
            endcase
          end
        end
      end

      ST_QUO: begin
        quo_next   = bpfd_pkg::tile_quot(pib, tw);
        state_next = ST_EMIT;
      end

      ST_EMIT: begin
        // Hold until the previous write can move to the output register.
        if (!pend_v || out_free) begin
          if (pend_v) begin
            out_valid_next = 1'b1;
            out_data_next  = pend;
          end
          pend_v_next = 1'b1;
          pend_next   = pix_word;
          if (pib_inc >= {1'b0, area}) begin
            tile_adv   = 1'b1;
            state_next = (nbits == '0) ? ST_END : ST_BIT;
          end else if (fill_mode) begin
            pib_next   = pib_inc[PibW-1:0];
            state_next = ST_QUO;
          end else begin
            pib_next   = pib_inc[PibW-1:0];
            need_next  = NeedW'(pbits);
            state_next = (nbits == '0) ? ST_END : ST_BIT;
          end
        end
      end

      ST_END: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          out_data_next  = close_word;
          pend_v_next    = 1'b0;
          state_next     = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase

    // Advance to the next tile; finish the frame past the bottom edge.
    if (tile_adv) begin
      pib_next   = '0;
      phase_next = PH_UPDATE;
      need_next  = NeedW'(1);
      acc_next   = '0;
      if (col_wrap) begin
        col_next = '0;
        row_next = row_inc[BlkW-1:0];
        if (row_wrap) begin
          finished_next = 1'b1;
        end
      end else begin
        col_next = col_inc[BlkW-1:0];
      end
    end
  end

  assign in_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      phase     <= PH_UPDATE;
      nbits     <= '0;
      acc       <= '0;
      need      <= NeedW'(1);
      pbits     <= '0;
      fill_cnt  <= '0;
      col       <= '0;
      row       <= '0;
      pib       <= '0;
      finished  <= 1'b1;
      fill_mode <= 1'b0;
      pend_v    <= 1'b0;
      out_valid <= 1'b0;
      cfg_w     <= bpfd_pkg::RESET_WIDTH;
      cfg_h     <= bpfd_pkg::RESET_HEIGHT;
    end else begin
      state     <= state_next;
      phase     <= phase_next;
      nbits     <= nbits_next;
      acc       <= acc_next;
      need      <= need_next;
      pbits     <= pbits_next;
      fill_cnt  <= fill_cnt_next;
      col       <= col_next;
      row       <= row_next;
      pib       <= pib_next;
      finished  <= finished_next;
      fill_mode <= fill_mode_next;
      pend_v    <= pend_v_next;
      out_valid <= out_valid_next;
      cfg_w     <= cfg_w_next;
      cfg_h     <= cfg_h_next;
    end
    shreg      <= shreg_next;
    fill_color <= fill_color_next;
    quo        <= quo_next;
    pend       <= pend_next;
    out_data   <= out_data_next;
  end

  // Palette: one write port while loading colours, one registered read per index.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      pal_mem[mem_waddr] <= acc_shift;
    end
    if (mem_re) begin
      rd_data <= pal_mem[mem_raddr];
    end
  end

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `BPFD_ASSERT(a_idle_no_pend, state == ST_IDLE, !pend_v)
  `BPFD_ASSERT(a_emit_live_frame, state == ST_EMIT, !finished)
  `BPFD_ASSERT(a_column_in_tile, state == ST_EMIT, rem_full < {2'b00, tw})
  `BPFD_ASSERT_NEXT(a_accept_parses, in_valid && in_ready, state == ST_BIT && nbits == 3'd0)

endmodule

>>> tb/block_palette_frame_decoder_tb.sv
`timescale 1ns / 1ps

module block_palette_frame_decoder_tb;

  // Allow the slowest correct run several times over: every word a 64-pixel
  // fill plus receiver stalls.
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_RESULTS = 64;
  localparam int WORDS_PER_SETTING = 17;
  localparam int REPORT_LIMIT = 10;

  localparam int BLOCK_SIZE  = bpfd_pkg::BLOCK_SIZE;
  localparam int PIX_W       = bpfd_pkg::PIX_W;
  localparam int COLOR_W     = bpfd_pkg::COLOR_W;
  localparam int CFG_W       = bpfd_pkg::CFG_W;
  localparam int CFG_IDX_W   = bpfd_pkg::CFG_IDX_W;
  localparam int DEF_MAX_DIM = bpfd_pkg::DEF_MAX_DIM;

  typedef enum logic [1:0] {
    EXPECT_UPDATE,
    EXPECT_PSIZE,
    EXPECT_COLOR,
    EXPECT_INDEX
  } parse_step_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  bpfd_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  bpfd_pkg::out_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = bpfd_pkg::REG_IMAGE_WIDTH;
  logic [CFG_W-1:0] cfg_wdata = '0;

  bpfd_pkg::in_t pending_words[$];
  bpfd_pkg::out_t expected_writes[$];
  bpfd_pkg::out_t byte_results[$];
  bit bit_buf[$];
  int mismatch_count = 0;
  int cycle_count = 0;
  bit no_idle = 1'b0;

  // Decoder state as the testbench sees it.
  int unsigned size_w, size_h;
  parse_step_t parse_step;
  logic [23:0] acc;
  int unsigned bits_needed, index_bits, fill_cnt;
  int unsigned tile_col, tile_row, pix_in_tile;
  bit finished;
  logic [COLOR_W-1:0] palette [256];

  block_palette_frame_decoder u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Pixel write prediction
  // ---------------------------------------------------------------------------

  // Saturate a size register to the largest frame dimension.
  function automatic int unsigned clip_dim(int unsigned v);
    return (v > DEF_MAX_DIM) ? DEF_MAX_DIM : v;
  endfunction

  // Tile extent along one axis; a tile wholly past the edge counts as one pixel.
  function automatic int unsigned tile_span(int unsigned origin, int unsigned limit);
    if (origin >= limit) return 1;
    return ((limit - origin) < BLOCK_SIZE) ? (limit - origin) : BLOCK_SIZE;
  endfunction

  function automatic void add_write(logic [COLOR_W-1:0] color);
    int unsigned x0, y0, tw;
    bpfd_pkg::out_t r;
    x0 = tile_col * BLOCK_SIZE;
    y0 = tile_row * BLOCK_SIZE;
    tw = tile_span(x0, clip_dim(size_w));
    if (byte_results.size() >= MAX_RESULTS) return;
    r = '0;
    r.write_enable = 1'b1;
    r.pixel_x = PIX_W'(x0 + pix_in_tile % tw);
    r.pixel_y = PIX_W'(y0 + pix_in_tile / tw);
    r.pixel_color = color;
    r.frame_done = finished;
    byte_results.push_back(r);
  endfunction

  // Move to the next tile in raster order; finish after the last row.
  function automatic void advance_tile();
    pix_in_tile = 0;
    parse_step = EXPECT_UPDATE;
    bits_needed = 1;
    acc = '0;
    tile_col++;
    if (tile_col * BLOCK_SIZE >= clip_dim(size_w)) begin
      tile_col = 0;
      tile_row++;
      if (tile_row * BLOCK_SIZE >= clip_dim(size_h)) finished = 1'b1;
    end
  endfunction

  function automatic void take_bit(bit b);
    logic [23:0] val;
    int unsigned area;
    if (finished) return;
    acc = {acc[22:0], b};
    if (bits_needed > 0) bits_needed--;
    if (bits_needed != 0) return;
    val = acc;
    acc = '0;
    area = tile_span(tile_col * BLOCK_SIZE, clip_dim(size_w)) *
           tile_span(tile_row * BLOCK_SIZE, clip_dim(size_h));
    case (parse_step)
      EXPECT_UPDATE: begin
        if (val[0]) begin
          parse_step = EXPECT_PSIZE;
          bits_needed = 3;
        end else begin
          advance_tile();
        end
      end
      EXPECT_PSIZE: begin
        index_bits = val[2:0];
        fill_cnt = 0;
        parse_step = EXPECT_COLOR;
        bits_needed = 24;
      end
      EXPECT_COLOR: begin
        palette[fill_cnt % 256] = val;
        fill_cnt++;
        if (fill_cnt < (1 << index_bits)) begin
          bits_needed = 24;
        end else if (index_bits != 0) begin
          parse_step = EXPECT_INDEX;
          pix_in_tile = 0;
          bits_needed = index_bits;
        end else begin
          // single-colour tile: flood the whole tile at once
          for (int i = 0; i < area; i++) begin
            pix_in_tile = i;
            add_write(palette[0]);
          end
          advance_tile();
        end
      end
      default: begin
        add_write(palette[val[6:0]]);
        pix_in_tile++;
        if (pix_in_tile >= area) advance_tile();
        else bits_needed = index_bits;
      end
    endcase
  endfunction

  // Work out every result one accepted word causes and queue them.
  function automatic void decode_byte(bpfd_pkg::in_t w);
    bpfd_pkg::out_t r;
    byte_results.delete();
    if (w.frame_start) begin
      parse_step = EXPECT_UPDATE;
      acc = '0;
      bits_needed = 1;
      index_bits = 0;
      fill_cnt = 0;
      tile_col = 0;
      tile_row = 0;
      pix_in_tile = 0;
      finished = (clip_dim(size_w) == 0 || clip_dim(size_h) == 0);
    end
    for (int k = 7; k >= 0; k--) take_bit(w.in_byte[k]);
    if (byte_results.size() == 0) byte_results.push_back('0);
    r = byte_results[$];
    r.last_of_run = 1'b1;
    r.frame_done = finished;
    byte_results[$] = r;
    foreach (byte_results[i]) expected_writes.push_back(byte_results[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic void queue_word(logic [7:0] b, bit start);
    bpfd_pkg::in_t w;
    w.in_byte = b;
    w.frame_start = start;
    pending_words.push_back(w);
  endfunction

  function automatic void put_bits(int unsigned v, int n);
    for (int i = n - 1; i >= 0; i--) bit_buf.push_back(v[i]);
  endfunction

  function automatic int unsigned rand_color();
    case ($urandom_range(7))
      0: return 0;
      1: return 24'hFFFFFF;
      default: return $urandom & 24'hFFFFFF;
    endcase
  endfunction

  // Mostly small palettes; large ones are rare since each colour costs 3 bytes.
  function automatic int unsigned pick_psize();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 40) return 0;
    if (r < 65) return 1;
    if (r < 82) return 2;
    if (r < 93) return 3;
    if (r < 98) return 4;
    return 5;
  endfunction

  // Pad the bit stream to whole bytes, then queue at most max_words of them.
  function automatic int flush_bits(bit start, int unsigned max_words);
    bpfd_pkg::in_t w;
    int count;
    if (bit_buf.size() == 0) put_bits($urandom, 8);
    while (bit_buf.size() % 8 != 0) bit_buf.push_back(1'($urandom));
    count = 0;
    while (bit_buf.size() != 0 && count < max_words) begin
      for (int i = 7; i >= 0; i--) w.in_byte[i] = bit_buf.pop_front();
      w.frame_start = start && (count == 0);
      pending_words.push_back(w);
      count++;
    end
    bit_buf.delete();
    return count;
  endfunction

  // Encode a well-formed frame for the current size with random tile content.
  function automatic int queue_frame(int unsigned max_words);
    int unsigned w, h, cols, area, psz, upd_pct;
    w = clip_dim(size_w);
    h = clip_dim(size_h);
    cols = (w + BLOCK_SIZE - 1) / BLOCK_SIZE;
    // wide frames: skip most tiles so rows actually wrap within the budget
    upd_pct = (cols > 32) ? 10 : 70;
    for (int unsigned y0 = 0; y0 < h && bit_buf.size() < 8 * max_words; y0 += BLOCK_SIZE) begin
      for (int unsigned x0 = 0; x0 < w && bit_buf.size() < 8 * max_words;
           x0 += BLOCK_SIZE) begin
        area = tile_span(x0, w) * tile_span(y0, h);
        if ($urandom_range(99) >= upd_pct) begin
          put_bits(0, 1);
        end else begin
          psz = pick_psize();
          put_bits(1, 1);
          put_bits(psz, 3);
          for (int i = 0; i < (1 << psz); i++) put_bits(rand_color(), 24);
          if (psz != 0)
            for (int i = 0; i < area; i++) put_bits($urandom_range((1 << psz) - 1), psz);
        end
      end
    end
    return flush_bits(1'b1, max_words);
  endfunction

  // Hold until every word is sent and every expected write has arrived.
  // Sample on the falling edge so the driver's updates have settled.
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_words.size() != 0 || in_valid || expected_writes.size() != 0);
  endtask

  task automatic write_size(int unsigned w, int unsigned h);
    wait_idle();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= bpfd_pkg::REG_IMAGE_WIDTH;
    cfg_wdata <= CFG_W'(w);
    @(posedge clk);
    cfg_index <= bpfd_pkg::REG_IMAGE_HEIGHT;
    cfg_wdata <= CFG_W'(h);
    @(posedge clk);
    cfg_we <= 1'b0;
    size_w = w;
    size_h = h;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: present the next pending word, idling at random between words.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pending_words.size() != 0 && (no_idle || $urandom_range(99) >= 13)) begin
        in_valid <= 1'b1;
        in_data <= pending_words.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: stall at random unless the calm stretch is on.
  always @(posedge clk) begin
    out_ready <= no_idle || ($urandom_range(99) >= 13);
  end

  function automatic void flag_mismatch(string what, bpfd_pkg::out_t want,
                                        bpfd_pkg::out_t got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      $display("%s: expected we=%0d x=%0d y=%0d color=%06h last=%0d done=%0d",
               what, want.write_enable, want.pixel_x, want.pixel_y, want.pixel_color,
               want.last_of_run, want.frame_done);
      $display("  got we=%0d x=%0d y=%0d color=%06h last=%0d done=%0d",
               got.write_enable, got.pixel_x, got.pixel_y, got.pixel_color,
               got.last_of_run, got.frame_done);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: check each accepted result against the oldest expectation and
  // predict the results of each accepted word.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    bpfd_pkg::out_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_writes.size() == 0) begin
          flag_mismatch("unexpected pixel word", '0, out_data);
        end else begin
          want = expected_writes.pop_front();
          if (out_data.write_enable !== want.write_enable ||
              out_data.pixel_x !== want.pixel_x ||
              out_data.pixel_y !== want.pixel_y ||
              out_data.pixel_color !== want.pixel_color ||
              out_data.last_of_run !== want.last_of_run ||
              out_data.frame_done !== want.frame_done)
            flag_mismatch("pixel word mismatch", want, out_data);
        end
      end
      if (in_valid && in_ready) decode_byte(in_data);
    end
  end

  // Drop the run if it hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int unsigned phase_words, budget, n, w_sel, h_sel;

    // reset view of the decoder: default size, idle until a frame start
    size_w = bpfd_pkg::RESET_WIDTH;
    size_h = bpfd_pkg::RESET_HEIGHT;
    parse_step = EXPECT_UPDATE;
    acc = '0;
    bits_needed = 1;
    index_bits = 0;
    fill_cnt = 0;
    tile_col = 0;
    tile_row = 0;
    pix_in_tile = 0;
    finished = 1'b1;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // --- directed part ---
    // a word before any frame start is ignored: status only
    queue_word(8'hA5, 1'b0);
    // frame at the reset size: eight skipped tiles
    queue_word(8'h00, 1'b1);

    // 12 x 10 frame: four tiles, three of them clipped, one on both edges
    write_size(12, 10);
    put_bits(0, 1);                           // skip
    put_bits(1, 1); put_bits(0, 3);           // flood fill, all ones
    put_bits(24'hFFFFFF, 24);
    put_bits(1, 1); put_bits(1, 3);           // two-colour tile, 16 indices
    put_bits(0, 24); put_bits(24'hFFFFFF, 24);
    put_bits($urandom, 16);
    put_bits(1, 1); put_bits(0, 3);           // flood fill, all zeros
    put_bits(0, 24);
    void'(flush_bits(1'b1, 64));              // trailing pad bits are ignored
    queue_word(8'h00, 1'b0);                  // frame already done

    // zero width: the frame has no tiles and finishes at once
    write_size(0, 10);
    queue_word(8'hFF, 1'b1);

    // oversized: both sizes saturate; restart a frame in mid-tile
    write_size(2047, 2047);
    queue_word(8'h00, 1'b1);
    queue_word(8'hFF, 1'b0);
    queue_word(8'h00, 1'b1);

    // shrink the width in mid-frame: the current tile now lies past the edge
    write_size(8, 2047);
    queue_word(8'h8F, 1'b0);
    queue_word(8'hFF, 1'b0);
    queue_word(8'hFF, 1'b0);
    queue_word(8'hF0, 1'b0);

    // --- random part: a few sizes, well-formed frames plus some noise ---
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin w_sel = 1; h_sel = $urandom_range(1, 24); end
        1: begin w_sel = $urandom_range(1, 24); h_sel = 1024; end
        2: begin w_sel = 2047; h_sel = $urandom_range(1, 16); end
        3: begin w_sel = $urandom_range(1, 24); h_sel = $urandom_range(1, 24); end
        4: begin w_sel = $urandom_range(25, 40); h_sel = $urandom_range(1, 24); end
        default: begin w_sel = $urandom_range(1, 20); h_sel = 1; end
      endcase
      write_size(w_sel, h_sel);
      // one setting runs with no idling on either side
      no_idle = (ph == 3);
      phase_words = 0;
      while (phase_words < WORDS_PER_SETTING) begin
        budget = WORDS_PER_SETTING - phase_words;
        if ($urandom_range(99) < 10) begin
          n = $urandom_range(1, 3);
          for (int i = 0; i < n; i++) queue_word(8'($urandom), $urandom_range(3) == 0);
          phase_words += n;
        end else begin
          // cut some frames short so the next frame start lands mid-frame
          phase_words += queue_frame(($urandom_range(4) == 0) ?
                                     $urandom_range(1, budget) : budget);
        end
      end
    end

    wait_idle();
    // leave room for a stray result after the last expected one
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/bpfd_pkg.sv
rtl/block_palette_frame_decoder.sv
tb/block_palette_frame_decoder_tb.sv
